[rtl/mstc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstc_pkg
// Shared codes, widths, the alert state type and the percent-to-duty mapping
// for the motor spin-up and trigger controller.
// ----------------------------------------------------------------------------
package mstc_pkg;

    localparam int IN_TDATA_W  = 40;  // now_ms, trigger_held, battery_low, pad
    localparam int OUT_TDATA_W = 16;  // motor_duty, motor_busy, drive_phase, alert_kind, pad
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int DEF_ALERT_PULSES   = 3;
    localparam int DEF_ALERT_DUTY_PCT = 30;

    // drive phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SPINUP = 2'd1;
    localparam logic [1:0] PH_CRUISE = 2'd2;

    // alert kind codes
    localparam logic [1:0] AL_NONE  = 2'd0;
    localparam logic [1:0] AL_INACT = 2'd1;
    localparam logic [1:0] AL_BATT  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SPIN_UP       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_QUICK_SPIN_UP = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REARM         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_PCT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_DELAY    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_REMIND_INT    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_ON      = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_OFF     = 3'd7;

    // floor(x/100) for x < 2^15 as (x * ceil(2^22/100)) >> 22
    localparam logic [30:0] DIV100_RECIP = 31'd41944;

    typedef struct packed {
        logic [1:0]  kind;
        logic        high;
        logic [7:0]  idx;
        logic [31:0] seg;
        logic [7:0]  duty;
    } alert_t;

    function automatic logic [7:0] pct_to_duty(input logic [6:0] p);
        logic [14:0] x;
        logic [30:0] q;
        x = {p, 8'd0} - 15'(p);
        q = 31'(x) * DIV100_RECIP;
        pct_to_duty = (p >= 7'd100) ? 8'd255 : q[29:22];
    endfunction

endpackage

[rtl/motor_spinup_trigger_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_spinup_trigger_controller
// Sequences motor duty through idle, spin-up and cruise from trigger samples,
// with pulsed low-battery and inactivity alerts.
// ----------------------------------------------------------------------------
// One sample is taken per clock unless m_tready holds the output back, and each
// sample yields exactly one result. The sample lands in an input register, the
// whole state update runs in one pass of compare-and-select logic against the
// registered timestamps, and the result is held in an output register that
// keeps accepting while m_tready is high. The cruise duty is converted from
// target_percent when that register is written. Write configuration only
// while no transaction is in flight.
module motor_spinup_trigger_controller #(
    parameter int ALERT_PULSES   = mstc_pkg::DEF_ALERT_PULSES,
    parameter int ALERT_DUTY_PCT = mstc_pkg::DEF_ALERT_DUTY_PCT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [mstc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mstc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] now_ms, [32] trigger_held, [33] battery_low, [39:34] zero
    input  logic [mstc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] motor_duty, [8] motor_busy, [10:9] drive_phase, [12:11] alert_kind,
    // [15:13] zero
    output logic [mstc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import mstc_pkg::*;

    localparam logic [7:0] PULSES_W   = 8'(ALERT_PULSES);
    localparam logic [7:0] ALERT_DUTY = pct_to_duty(7'(ALERT_DUTY_PCT));

    // configuration
    logic [15:0] spin_up_reg, quick_spin_up_reg, rearm_reg;
    logic [15:0] pulse_on_reg, pulse_off_reg;
    logic [31:0] idle_delay_reg, remind_int_reg;
    logic [7:0]  target_duty_reg;

    // input stage
    logic        in_valid_reg;
    logic [31:0] in_now_reg;
    logic        in_held_reg, in_low_reg;

    // controller state
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] phase_start_reg, phase_start_next;
    logic [15:0] active_spin_up_reg, active_spin_up_next;
    logic [31:0] release_start_reg, release_start_next;
    logic        prev_trigger_reg, prev_trigger_next;
    logic        armed_reg, armed_next;
    logic [31:0] last_press_reg, last_press_next;
    logic [31:0] last_reminder_reg, last_reminder_next;
    alert_t      alert_reg, alert_next;

    // output stage
    logic        out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic advance;
    logic alert_run;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    function automatic alert_t alert_begin(input logic [1:0] kind, input logic [31:0] now,
                                           input logic [7:0] duty_in);
        alert_t a;
        a.kind = kind;
        a.high = 1'b1;
        a.idx  = 8'd0;
        a.seg  = now;
        a.duty = duty_in;
        return a;
    endfunction

    // advance a running alert; run reports whether it is still going
    function automatic alert_t alert_tick(input alert_t a, input logic [31:0] now,
                                          input logic [15:0] on_ms,
                                          input logic [15:0] off_ms, output logic run);
        alert_t      r;
        logic [31:0] elapsed;
        logic [7:0]  idx_inc;
        r       = a;
        run     = 1'b1;
        elapsed = now - a.seg;
        idx_inc = a.idx + 8'd1;
        if (a.kind == AL_NONE) begin
            run = 1'b0;
        end else if (a.high) begin
            if (elapsed >= {16'd0, on_ms}) begin
                r.high = 1'b0;
                r.seg  = now;
                r.duty = 8'd0;
            end
        end else if (elapsed >= {16'd0, off_ms}) begin
            if (idx_inc >= PULSES_W) begin
                r.kind = AL_NONE;
                r.high = 1'b0;
                r.idx  = 8'd0;
                r.duty = 8'd0;
                run    = 1'b0;
            end else begin
                r.idx  = idx_inc;
                r.high = 1'b1;
                r.seg  = now;
                r.duty = ALERT_DUTY;
            end
        end
        return r;
    endfunction

    always_comb begin
        phase_next          = phase_reg;
        phase_start_next    = phase_start_reg;
        active_spin_up_next = active_spin_up_reg;
        release_start_next  = release_start_reg;
        armed_next          = armed_reg;
        last_press_next     = last_press_reg;
        last_reminder_next  = last_reminder_reg;
        alert_next          = alert_reg;
        prev_trigger_next   = in_held_reg;
        alert_run           = 1'b0;

        if (in_held_reg && !prev_trigger_reg) begin
            last_press_next    = in_now_reg;
            last_reminder_next = in_now_reg;
        end

        if (in_held_reg && in_low_reg) begin
            // battery block: motor off, alert only on the press edge
            phase_next         = PH_IDLE;
            armed_next         = 1'b0;
            release_start_next = in_now_reg;
            if (alert_next.kind == AL_INACT) begin
                alert_next.kind = AL_NONE;
                alert_next.high = 1'b0;
                alert_next.idx  = 8'd0;
            end
            if (!prev_trigger_reg && alert_next.kind == AL_NONE) begin
                alert_next = alert_begin(AL_BATT, in_now_reg, ALERT_DUTY);
            end
            alert_next = alert_tick(alert_next, in_now_reg, pulse_on_reg, pulse_off_reg,
                                    alert_run);
            if (!alert_run) begin
                alert_next.duty = 8'd0;
            end
        end else if (!in_held_reg) begin
            if (prev_trigger_reg) begin
                release_start_next = in_now_reg;
                armed_next         = 1'b0;
            end
            if (phase_reg != PH_IDLE) begin
                phase_next      = PH_IDLE;
                alert_next.duty = 8'd0;
            end
            if (!armed_next && (in_now_reg - release_start_next) >= {16'd0, rearm_reg}) begin
                armed_next = 1'b1;
            end
            if ((in_now_reg - last_press_next) >= idle_delay_reg &&
                (in_now_reg - last_reminder_next) >= remind_int_reg) begin
                alert_next         = alert_begin(AL_INACT, in_now_reg, ALERT_DUTY);
                last_reminder_next = in_now_reg;
            end
            alert_next = alert_tick(alert_next, in_now_reg, pulse_on_reg, pulse_off_reg,
                                    alert_run);
        end else begin
            // press without a battery block: drop any alert, drive the motor
            if (alert_next.kind != AL_NONE) begin
                alert_next.kind = AL_NONE;
                alert_next.high = 1'b0;
                alert_next.idx  = 8'd0;
                alert_next.duty = 8'd0;
            end
            if (!prev_trigger_reg && phase_reg == PH_IDLE) begin
                phase_start_next    = in_now_reg;
                active_spin_up_next = armed_reg ? spin_up_reg : quick_spin_up_reg;
                if (active_spin_up_next == 16'd0) begin
                    phase_next      = PH_CRUISE;
                    alert_next.duty = target_duty_reg;
                end else begin
                    phase_next      = PH_SPINUP;
                    alert_next.duty = 8'd255;
                end
            end else if (phase_reg == PH_IDLE) begin
                alert_next.duty = target_duty_reg;
            end
            if (phase_next == PH_SPINUP &&
                (in_now_reg - phase_start_next) >= {16'd0, active_spin_up_next}) begin
                phase_next      = PH_CRUISE;
                alert_next.duty = target_duty_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spin_up_reg       <= 16'd300;
            quick_spin_up_reg <= 16'd100;
            rearm_reg         <= 16'd1000;
            target_duty_reg   <= pct_to_duty(7'd70);
            idle_delay_reg    <= 32'd300000;
            remind_int_reg    <= 32'd60000;
            pulse_on_reg      <= 16'd200;
            pulse_off_reg     <= 16'd200;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SPIN_UP:       spin_up_reg       <= cfg_wdata[15:0];
                REG_QUICK_SPIN_UP: quick_spin_up_reg <= cfg_wdata[15:0];
                REG_REARM:         rearm_reg         <= cfg_wdata[15:0];
                REG_TARGET_PCT:    target_duty_reg   <= pct_to_duty(cfg_wdata[6:0]);
                REG_IDLE_DELAY:    idle_delay_reg    <= cfg_wdata;
                REG_REMIND_INT:    remind_int_reg    <= cfg_wdata;
                REG_PULSE_ON:      pulse_on_reg      <= cfg_wdata[15:0];
                REG_PULSE_OFF:     pulse_off_reg     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_now_reg  <= s_tdata[31:0];
            in_held_reg <= s_tdata[32];
            in_low_reg  <= s_tdata[33];
        end
    end

    // controller state, updated once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            phase_start_reg    <= '0;
            active_spin_up_reg <= '0;
            release_start_reg  <= '0;
            prev_trigger_reg   <= 1'b0;
            armed_reg          <= 1'b1;
            last_press_reg     <= '0;
            last_reminder_reg  <= '0;
            alert_reg          <= '{kind: AL_NONE, high: 1'b0, idx: 8'd0, seg: 32'd0,
                                    duty: 8'd0};
        end else if (advance) begin
            phase_reg          <= phase_next;
            phase_start_reg    <= phase_start_next;
            active_spin_up_reg <= active_spin_up_next;
            release_start_reg  <= release_start_next;
            prev_trigger_reg   <= prev_trigger_next;
            armed_reg          <= armed_next;
            last_press_reg     <= last_press_next;
            last_reminder_reg  <= last_reminder_next;
            alert_reg          <= alert_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {3'd0, alert_next.kind, phase_next,
                             (phase_next != PH_IDLE) || (alert_next.kind != AL_NONE),
                             alert_next.duty};
        end
    end

    // alerts only ever run with the motor idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_IDLE |-> alert_reg.kind == AL_NONE)
        else $error("alert running while motor phase is active");

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SPINUP |-> alert_reg.duty == 8'd255)
        else $error("spin-up without full duty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        alert_reg.kind == AL_NONE |-> !alert_reg.high && alert_reg.idx == 8'd0)
        else $error("stale pulse state with no alert");

    assert property (@(posedge aclk) disable iff (!aresetn)
        alert_reg.idx < PULSES_W)
        else $error("pulse count past its limit");

endmodule

[test/motor_spinup_trigger_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_spinup_trigger_controller_tb
// Drives timestamped trigger/battery samples into the controller and checks
// every result against a cycle-free predictor of the duty, phase and alert
// sequencing. Directed cases cover spin-up, quick re-press, re-arm, battery
// block, inactivity reminders and register extremes; random bursts of
// press/release sequences follow under three source/sink stall mixes.
// ----------------------------------------------------------------------------
module motor_spinup_trigger_controller_tb;
    import mstc_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int BATCH_ITEMS   = 250;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0] duty;
        logic       busy;
        logic [1:0] phase;
        logic [1:0] alert;
    } motor_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    motor_spinup_trigger_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // predictor copy of the configuration
    logic [15:0] spin_full_ms   = 16'd300;
    logic [15:0] spin_quick_ms  = 16'd100;
    logic [15:0] rearm_hold_ms  = 16'd1000;
    logic [6:0]  cruise_pct     = 7'd70;
    logic [31:0] idle_wait_ms   = 32'd300000;
    logic [31:0] remind_gap_ms  = 32'd60000;
    logic [15:0] beep_on_ms     = 16'd200;
    logic [15:0] beep_off_ms    = 16'd200;

    // predictor copy of the controller state
    logic [1:0]  drive_ph       = PH_IDLE;
    logic [31:0] drive_since    = '0;
    logic [15:0] spin_len       = '0;
    logic [31:0] released_at    = '0;
    logic        was_held       = 1'b0;
    logic        rearmed        = 1'b1;
    logic [31:0] pressed_at     = '0;
    logic [31:0] reminded_at    = '0;
    logic [1:0]  alert_now      = AL_NONE;
    logic        beep_high      = 1'b0;
    logic [7:0]  beep_count     = '0;
    logic [31:0] beep_since     = '0;
    logic [7:0]  duty_now       = '0;

    motor_result_t pending_results[$];
    motor_result_t observed, predicted;
    int          fail_count     = 0;
    int          sample_count   = 0;
    int          stall_cycles   = 0;
    int          src_idle_pct   = 0;
    int          sink_idle_pct  = 0;
    logic [31:0] clock_ms       = '0;

    function automatic logic [7:0] percent_duty(input logic [6:0] pct);
        int unsigned scaled;
        scaled = pct;
        if (scaled >= 100) return 8'd255;
        return 8'((scaled * 255) / 100);
    endfunction

    function automatic void stop_alert();
        alert_now  = AL_NONE;
        beep_high  = 1'b0;
        beep_count = '0;
    endfunction

    function automatic void start_alert(input logic [1:0] kind, input logic [31:0] now);
        alert_now  = kind;
        beep_high  = 1'b1;
        beep_count = '0;
        beep_since = now;
        duty_now   = percent_duty(7'(DEF_ALERT_DUTY_PCT));
    endfunction

    // advance a running alert; 1 while it still runs
    function automatic logic tick_alert(input logic [31:0] now);
        if (alert_now == AL_NONE) return 1'b0;
        if (beep_high) begin
            if (32'(now - beep_since) >= {16'd0, beep_on_ms}) begin
                beep_high  = 1'b0;
                beep_since = now;
                duty_now   = '0;
            end
            return 1'b1;
        end
        if (32'(now - beep_since) < {16'd0, beep_off_ms}) return 1'b1;
        beep_count = beep_count + 8'd1;
        if (beep_count >= 8'(DEF_ALERT_PULSES)) begin
            stop_alert();
            duty_now = '0;
            return 1'b0;
        end
        beep_high  = 1'b1;
        beep_since = now;
        duty_now   = percent_duty(7'(DEF_ALERT_DUTY_PCT));
        return 1'b1;
    endfunction

    function automatic motor_result_t advance_controller(input logic [31:0] now,
                                                         input logic held,
                                                         input logic low);
        motor_result_t res;
        if (held && !was_held) begin
            pressed_at  = now;
            reminded_at = now;
        end
        if (held && low) begin
            drive_ph    = PH_IDLE;
            rearmed     = 1'b0;
            released_at = now;
            if (alert_now == AL_INACT) stop_alert();
            if (!was_held && alert_now == AL_NONE) start_alert(AL_BATT, now);
            if (!tick_alert(now)) duty_now = '0;
        end else if (!held) begin
            if (was_held) begin
                released_at = now;
                rearmed     = 1'b0;
            end
            if (drive_ph != PH_IDLE) begin
                drive_ph = PH_IDLE;
                duty_now = '0;
            end
            if (!rearmed && 32'(now - released_at) >= {16'd0, rearm_hold_ms}) rearmed = 1'b1;
            if (32'(now - pressed_at) >= idle_wait_ms &&
                32'(now - reminded_at) >= remind_gap_ms) begin
                start_alert(AL_INACT, now);
                reminded_at = now;
            end
            void'(tick_alert(now));
        end else begin
            if (alert_now != AL_NONE) begin
                stop_alert();
                duty_now = '0;
            end
            if (!was_held && drive_ph == PH_IDLE) begin
                drive_since = now;
                spin_len    = rearmed ? spin_full_ms : spin_quick_ms;
                if (spin_len == 16'd0) begin
                    drive_ph = PH_CRUISE;
                    duty_now = percent_duty(cruise_pct);
                end else begin
                    drive_ph = PH_SPINUP;
                    duty_now = 8'd255;
                end
            end else if (drive_ph == PH_IDLE) begin
                // held across a battery block: duty follows cruise, phase stays idle
                duty_now = percent_duty(cruise_pct);
            end
            if (drive_ph == PH_SPINUP && 32'(now - drive_since) >= {16'd0, spin_len}) begin
                drive_ph = PH_CRUISE;
                duty_now = percent_duty(cruise_pct);
            end
        end
        was_held  = held;
        res.duty  = duty_now;
        res.busy  = (drive_ph != PH_IDLE) || (alert_now != AL_NONE);
        res.phase = drive_ph;
        res.alert = alert_now;
        return res;
    endfunction

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // predict on every accepted sample, check every accepted result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pending_results.push_back(advance_controller(s_tdata[31:0], s_tdata[32],
                                                             s_tdata[33]));
            if (m_tvalid && m_tready) begin
                observed = '{duty: m_tdata[7:0], busy: m_tdata[8], phase: m_tdata[10:9],
                             alert: m_tdata[12:11]};
                if (pending_results.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected result %h with nothing pending",
                                 $realtime, m_tdata);
                    fail_count++;
                end else begin
                    predicted = pending_results.pop_front();
                    if (observed.duty !== predicted.duty || observed.busy !== predicted.busy ||
                        observed.phase !== predicted.phase ||
                        observed.alert !== predicted.alert) begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%0t: mismatch exp duty %0d busy %0d phase %0d alert %0d,",
                                     $realtime, predicted.duty, predicted.busy,
                                     predicted.phase, predicted.alert,
                                     " got duty %0d busy %0d phase %0d alert %0d",
                                     observed.duty, observed.busy, observed.phase,
                                     observed.alert);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_sample(input logic [31:0] now, input logic held, input logic low);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, low, held, now};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sample_count++;
    endtask

    // hold the source until every pending result is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_SPIN_UP:       spin_full_ms  = value[15:0];
            REG_QUICK_SPIN_UP: spin_quick_ms = value[15:0];
            REG_REARM:         rearm_hold_ms = value[15:0];
            REG_TARGET_PCT:    cruise_pct    = value[6:0];
            REG_IDLE_DELAY:    idle_wait_ms  = value;
            REG_REMIND_INT:    remind_gap_ms = value;
            REG_PULSE_ON:      beep_on_ms    = value[15:0];
            REG_PULSE_OFF:     beep_off_ms   = value[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_setting(input logic [31:0] top, input int span);
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return top;
        return $urandom_range(span);
    endfunction

    task automatic random_config();
        write_reg(REG_SPIN_UP,       pick_setting(32'hFFFF, 400));
        write_reg(REG_QUICK_SPIN_UP, pick_setting(32'hFFFF, 200));
        write_reg(REG_REARM,         pick_setting(32'hFFFF, 1500));
        write_reg(REG_TARGET_PCT,    pick_setting(32'd127, 110));
        write_reg(REG_IDLE_DELAY,    pick_setting(32'hFFFF_FFFF, 3000));
        write_reg(REG_REMIND_INT,    pick_setting(32'hFFFF_FFFF, 2000));
        write_reg(REG_PULSE_ON,      pick_setting(32'hFFFF, 300));
        write_reg(REG_PULSE_OFF,     pick_setting(32'hFFFF, 300));
    endtask

    task automatic step_clock();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)      clock_ms = clock_ms + $urandom_range(40);
        else if (pick < 85) clock_ms = clock_ms + $urandom_range(400, 41);
        else if (pick < 97) clock_ms = clock_ms + $urandom_range(3000, 401);
        else                clock_ms = $urandom();
    endtask

    task automatic test_default_drive();
        send_sample(32'd0,    1'b0, 1'b0);
        send_sample(32'd10,   1'b1, 1'b0);   // armed press: full spin-up
        send_sample(32'd200,  1'b1, 1'b0);
        send_sample(32'd310,  1'b1, 1'b0);   // spin-up done: cruise
        send_sample(32'd400,  1'b0, 1'b0);
        send_sample(32'd500,  1'b1, 1'b0);   // re-press before re-arm: quick spin-up
        send_sample(32'd600,  1'b1, 1'b0);
        send_sample(32'd700,  1'b0, 1'b0);
        send_sample(32'd1800, 1'b0, 1'b0);   // released long enough to re-arm
    endtask

    task automatic test_battery_block();
        send_sample(32'd1900, 1'b1, 1'b1);   // press on low battery: alert, no drive
        send_sample(32'd2150, 1'b1, 1'b1);
        send_sample(32'd2200, 1'b1, 1'b0);   // still held after block clears
        send_sample(32'd2300, 1'b0, 1'b0);   // release keeps that duty
    endtask

    task automatic test_inactivity_reminder();
        wait_idle();
        write_reg(REG_IDLE_DELAY, 32'd50);
        write_reg(REG_REMIND_INT, 32'd0);
        write_reg(REG_PULSE_ON,   32'd0);
        write_reg(REG_PULSE_OFF,  32'd0);
        send_sample(32'd2400, 1'b0, 1'b0);
        send_sample(32'd2401, 1'b0, 1'b0);
        send_sample(32'd2402, 1'b1, 1'b0);   // press while reminder runs
        send_sample(32'd2403, 1'b1, 1'b1);   // battery drops while held
        send_sample(32'd2404, 1'b0, 1'b0);
    endtask

    task automatic test_config_extremes();
        wait_idle();
        write_reg(REG_SPIN_UP,    32'd0);
        write_reg(REG_TARGET_PCT, 32'd127);
        send_sample(32'hFFFF_FFF0, 1'b1, 1'b0);  // not re-armed: quick spin-up, the zero spin-up is unused
        send_sample(32'h0000_0005, 1'b1, 1'b0);  // timestamp wraps
        send_sample(32'h0000_000A, 1'b0, 1'b0);
        wait_idle();
        write_reg(REG_TARGET_PCT, 32'd0);
        send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
        wait_idle();
        write_reg(REG_TARGET_PCT, 32'd100);
        write_reg(REG_SPIN_UP,       32'hFFFF);
        write_reg(REG_QUICK_SPIN_UP, 32'hFFFF);
        write_reg(REG_REARM,         32'hFFFF);
        write_reg(REG_IDLE_DELAY,    32'hFFFF_FFFF);
        write_reg(REG_REMIND_INT,    32'hFFFF_FFFF);
        write_reg(REG_PULSE_ON,      32'hFFFF);
        write_reg(REG_PULSE_OFF,     32'hFFFF);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h0000_0000, 1'b1, 1'b1);
        send_sample(32'h0001_0000, 1'b1, 1'b0);
    endtask

    // mostly release/press sequences with random timing, some raw noise
    task automatic play_random_bursts(input int n_items);
        int stop_at;
        int len;
        logic low_mode;
        stop_at = sample_count + n_items;
        while (sample_count < stop_at) begin
            if ($urandom_range(9) < 2) begin
                len = $urandom_range(6, 1);
                repeat (len) begin
                    step_clock();
                    send_sample(clock_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end else begin
                len = $urandom_range(12, 1);
                repeat (len) begin
                    step_clock();
                    send_sample(clock_ms, 1'b0, 1'($urandom_range(9) == 0));
                end
                low_mode = ($urandom_range(99) < 15);
                len = $urandom_range(15, 1);
                repeat (len) begin
                    step_clock();
                    if ($urandom_range(19) == 0) low_mode = ~low_mode;
                    send_sample(clock_ms, 1'b1, low_mode);
                end
            end
            if ($urandom_range(49) == 0) wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        int mode;
        for (mode = 0; mode < 3; mode++) begin
            src_idle_pct  = (mode == 0) ? 18 : (mode == 1) ? 72 : 0;
            sink_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 18 : 0;
            repeat (2) begin
                wait_idle();
                random_config();
                play_random_bursts(BATCH_ITEMS);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_drive();
        test_battery_block();
        test_inactivity_reminder();
        test_config_extremes();
        test_random_traffic();
        wait_idle();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mstc_pkg.sv
rtl/motor_spinup_trigger_controller.sv
test/motor_spinup_trigger_controller_tb.sv
